@@ rtl/core/rim_pkg.sv @@
// Shared constants for the rotozoom inverse mapper: register indexes and fixed widths.
package rim_pkg;

   localparam int CSR_INDEX_BITS = 3;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type CSR_COEF_COS      = csr_index_type'(0);
   localparam csr_index_type CSR_COEF_SIN      = csr_index_type'(1);
   localparam csr_index_type CSR_DEST_CENTER_X = csr_index_type'(2);
   localparam csr_index_type CSR_DEST_CENTER_Y = csr_index_type'(3);
   localparam csr_index_type CSR_SRC_WIDTH     = csr_index_type'(4);
   localparam csr_index_type CSR_SRC_HEIGHT    = csr_index_type'(5);

endpackage

@@ rtl/core/rim_if.sv @@
// Valid/ready channel interfaces for the rotozoom inverse mapper.
interface rim_req_if #(
   parameter int COORD_BITS = 12
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] dest_x;
   logic [COORD_BITS-1:0] dest_y;

   modport source (output valid, output dest_x, output dest_y, input ready);
   modport sink   (input valid, input dest_x, input dest_y, output ready);
endinterface

interface rim_rsp_if #(
   parameter int OUT_BITS = 8
);
   logic                valid;
   logic                ready;
   logic                hit;
   logic [OUT_BITS-1:0] src_x;
   logic [OUT_BITS-1:0] src_y;

   modport source (output valid, output hit, output src_x, output src_y, input ready);
   modport sink   (input valid, input hit, input src_x, input src_y, output ready);
endinterface

interface rim_csr_if #(
   parameter int DATA_BITS = 18
);
   import rim_pkg::*;
   logic                 valid;
   logic                 ready;
   csr_index_type        index;
   logic [DATA_BITS-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/rotozoom_inverse_map_top.sv @@
// Rotozoom inverse mapper: destination pixel to rounded source-grid coordinate and hit flag.
//
// One destination coordinate is accepted per clock and one result leaves per clock
// while the response channel is not stalled. The datapath is five register stages
// (input, four products, two sums, rounding, bounds check and result). Each stage holds
// its item while the stage after it is full and stalled, so empty stages keep filling
// under a stalled response channel. Coefficients are signed with FRAC_BITS fraction
// bits; the response interface must carry clog2(SRC_MAX) bits per coordinate and the CSR
// interface the widest register. The user must write registers only while no transaction
// is in flight; the block does not enforce this. csr ready is always high.
module rotozoom_inverse_map_top #(
   parameter int COORD_BITS = 12,
   parameter int SRC_MAX    = 256,
   parameter int FRAC_BITS  = 16
) (
   input  logic   clock,
   input  logic   reset,
   rim_req_if.sink   req_chan,
   rim_rsp_if.source rsp_chan,
   rim_csr_if.sink   csr_chan
);
   import rim_pkg::*;

   localparam int COEF_BITS = FRAC_BITS + 2;
   localparam int OUT_BITS  = $clog2(SRC_MAX);
   localparam int SIZE_BITS = OUT_BITS + 1;
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int PROD_BITS = COEF_BITS + DIFF_BITS;
   localparam int ACC_BITS  = PROD_BITS + 2;
   localparam int RND_BITS  = ACC_BITS - FRAC_BITS;
   localparam logic [ACC_BITS-1:0] HALF = {{(ACC_BITS-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
   localparam logic [SIZE_BITS-1:0] SIZE_MAX = SIZE_BITS'(SRC_MAX);

   // configuration registers
   logic signed [COEF_BITS-1:0]  coef_cos_ff;
   logic signed [COEF_BITS-1:0]  coef_sin_ff;
   logic        [COORD_BITS-1:0] center_x_ff;
   logic        [COORD_BITS-1:0] center_y_ff;
   logic        [SIZE_BITS-1:0]  width_ff;
   logic        [SIZE_BITS-1:0]  height_ff;
   logic        [SIZE_BITS-1:0]  size_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      size_in = csr_chan.data[SIZE_BITS-1:0];
      if (size_in > SIZE_MAX) begin
         size_in = SIZE_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_cos_ff <= COEF_BITS'(1) << FRAC_BITS;
         coef_sin_ff <= '0;
         center_x_ff <= '0;
         center_y_ff <= '0;
         width_ff    <= SIZE_BITS'(1);
         height_ff   <= SIZE_BITS'(1);
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_COEF_COS:      coef_cos_ff <= csr_chan.data[COEF_BITS-1:0];
            CSR_COEF_SIN:      coef_sin_ff <= csr_chan.data[COEF_BITS-1:0];
            CSR_DEST_CENTER_X: center_x_ff <= csr_chan.data[COORD_BITS-1:0];
            CSR_DEST_CENTER_Y: center_y_ff <= csr_chan.data[COORD_BITS-1:0];
            CSR_SRC_WIDTH:     width_ff    <= size_in;
            CSR_SRC_HEIGHT:    height_ff   <= size_in;
            default: ;
         endcase
      end
   end

   // source centre (size - 1) / 2 in coefficient format, size may be 0
   logic signed [SIZE_BITS:0]   width_m1;
   logic signed [SIZE_BITS:0]   height_m1;
   logic signed [ACC_BITS-1:0]  ctr_x;
   logic signed [ACC_BITS-1:0]  ctr_y;

   assign width_m1  = $signed({1'b0, width_ff}) - $signed((SIZE_BITS + 1)'(1));
   assign height_m1 = $signed({1'b0, height_ff}) - $signed((SIZE_BITS + 1)'(1));
   assign ctr_x     = ACC_BITS'(width_m1) <<< (FRAC_BITS - 1);
   assign ctr_y     = ACC_BITS'(height_m1) <<< (FRAC_BITS - 1);

   // stage handshake
   logic v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy0, rdy1, rdy2, rdy3, rdy4;

   assign rdy4 = !v4_ff || rsp_chan.ready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign rdy0 = !v0_ff || rdy1;
   assign req_chan.ready = rdy0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy0) begin
            v0_ff <= req_chan.valid;
         end
         if (rdy1) begin
            v1_ff <= v0_ff;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
         if (rdy4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   // stage 0: input register
   logic [COORD_BITS-1:0] dx_ff, dy_ff;

   always_ff @(posedge clock) begin
      if (rdy0 && req_chan.valid) begin
         dx_ff <= req_chan.dest_x;
         dy_ff <= req_chan.dest_y;
      end
   end

   // stage 1: centre offset and products
   logic signed [DIFF_BITS-1:0] px_in, py_in;
   logic signed [PROD_BITS-1:0] cos_px_in, sin_py_in, sin_px_in, cos_py_in;
   logic signed [PROD_BITS-1:0] cos_px_ff, sin_py_ff, sin_px_ff, cos_py_ff;

   assign px_in     = $signed({1'b0, dx_ff}) - $signed({1'b0, center_x_ff});
   assign py_in     = $signed({1'b0, dy_ff}) - $signed({1'b0, center_y_ff});
   assign cos_px_in = coef_cos_ff * px_in;
   assign sin_py_in = coef_sin_ff * py_in;
   assign sin_px_in = coef_sin_ff * px_in;
   assign cos_py_in = coef_cos_ff * py_in;

   always_ff @(posedge clock) begin
      if (rdy1 && v0_ff) begin
         cos_px_ff <= cos_px_in;
         sin_py_ff <= sin_py_in;
         sin_px_ff <= sin_px_in;
         cos_py_ff <= cos_py_in;
      end
   end

   // stage 2: sums
   logic signed [ACC_BITS-1:0] sum_x_in, sum_y_in;
   logic signed [ACC_BITS-1:0] sum_x_ff, sum_y_ff;

   assign sum_x_in = ACC_BITS'(cos_px_ff) + ACC_BITS'(sin_py_ff) + ctr_x;
   assign sum_y_in = ACC_BITS'(cos_py_ff) - ACC_BITS'(sin_px_ff) + ctr_y;

   always_ff @(posedge clock) begin
      if (rdy2 && v1_ff) begin
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
      end
   end

   // stage 3: round magnitude half away from zero
   logic                neg_x_in, neg_y_in;
   logic [ACC_BITS-1:0] mag_x, mag_y, bias_x, bias_y;
   logic [RND_BITS-1:0] rnd_x_in, rnd_y_in;
   logic                neg_x_ff, neg_y_ff;
   logic [RND_BITS-1:0] rnd_x_ff, rnd_y_ff;

   assign neg_x_in = sum_x_ff[ACC_BITS-1];
   assign neg_y_in = sum_y_ff[ACC_BITS-1];
   assign mag_x    = neg_x_in ? ACC_BITS'(-sum_x_ff) : ACC_BITS'(sum_x_ff);
   assign mag_y    = neg_y_in ? ACC_BITS'(-sum_y_ff) : ACC_BITS'(sum_y_ff);
   assign bias_x   = mag_x + HALF;
   assign bias_y   = mag_y + HALF;
   assign rnd_x_in = bias_x[ACC_BITS-1:FRAC_BITS];
   assign rnd_y_in = bias_y[ACC_BITS-1:FRAC_BITS];

   always_ff @(posedge clock) begin
      if (rdy3 && v2_ff) begin
         neg_x_ff <= neg_x_in;
         neg_y_ff <= neg_y_in;
         rnd_x_ff <= rnd_x_in;
         rnd_y_ff <= rnd_y_in;
      end
   end

   // stage 4: bounds check and result register; a negative value rounding to 0 still hits
   logic [RND_BITS-1:0] ox, oy;
   logic                ok_x, ok_y, hit_in;
   logic                hit_ff;
   logic [OUT_BITS-1:0] out_x_ff, out_y_ff;

   assign ox     = neg_x_ff ? '0 : rnd_x_ff;
   assign oy     = neg_y_ff ? '0 : rnd_y_ff;
   assign ok_x   = (!neg_x_ff || rnd_x_ff == '0) && (ox < RND_BITS'(width_ff));
   assign ok_y   = (!neg_y_ff || rnd_y_ff == '0) && (oy < RND_BITS'(height_ff));
   assign hit_in = ok_x && ok_y;

   always_ff @(posedge clock) begin
      if (rdy4 && v3_ff) begin
         hit_ff   <= hit_in;
         out_x_ff <= hit_in ? ox[OUT_BITS-1:0] : '0;
         out_y_ff <= hit_in ? oy[OUT_BITS-1:0] : '0;
      end
   end

   assign rsp_chan.valid = v4_ff;
   assign rsp_chan.hit   = hit_ff;
   assign rsp_chan.src_x = out_x_ff;
   assign rsp_chan.src_y = out_y_ff;

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      v4_ff && !hit_ff |-> out_x_ff == '0 && out_y_ff == '0)
      else $error("miss transaction carries nonzero coordinates");

   a_round_hold: assert property (@(posedge clock) disable iff (reset)
      v3_ff && !rdy4 |=> v3_ff)
      else $error("rounding stage dropped a transaction under stall");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !v4_ff && !v0_ff)
      else $error("pipeline not empty after reset");

endmodule

@@ tb/sv/rotozoom_inverse_map_checker.sv @@
// Scoreboard for the rotozoom inverse mapper: tracks the CSRs, predicts each result and compares.
module rotozoom_inverse_map_checker #(
   parameter int COORD_BITS = 12,
   parameter int SRC_MAX    = 256,
   parameter int FRAC_BITS  = 16,
   parameter int OUT_BITS   = 8
) (
   input  logic clock,
   input  logic reset,
   rim_req_if   req_mon,
   rim_rsp_if   rsp_mon,
   rim_csr_if   csr_mon,
   output int   fail_count,
   output int   pending_results
);
   timeunit 1ns;
   timeprecision 1ps;
   import rim_pkg::*;

   localparam int     COEF_BITS = FRAC_BITS + 2;
   localparam int     SIZE_BITS = $clog2(SRC_MAX) + 1;
   localparam longint HALF      = longint'(1) << (FRAC_BITS - 1);

   typedef struct {
      logic [COORD_BITS-1:0] dest_x;
      logic [COORD_BITS-1:0] dest_y;
      logic                  hit;
      logic [OUT_BITS-1:0]   src_x;
      logic [OUT_BITS-1:0]   src_y;
   } src_point_type;

   logic signed [COEF_BITS-1:0] coef_cos;
   logic signed [COEF_BITS-1:0] coef_sin;
   logic [COORD_BITS-1:0]       center_x;
   logic [COORD_BITS-1:0]       center_y;
   int                          src_w;
   int                          src_h;
   src_point_type               src_point_q[$];

   function automatic longint round_half_away(longint v);
      if (v >= 0) begin
         return (v + HALF) >>> FRAC_BITS;
      end
      return -((-v + HALF) >>> FRAC_BITS);
   endfunction

   function automatic int clamp_size(logic [SIZE_BITS-1:0] v);
      return (v > SRC_MAX) ? SRC_MAX : int'(v);
   endfunction

   function automatic src_point_type map_pixel(logic [COORD_BITS-1:0] x,
                                               logic [COORD_BITS-1:0] y);
      longint        px, py, sx, sy, ox, oy;
      src_point_type p;
      px = longint'(x) - longint'(center_x);
      py = longint'(y) - longint'(center_y);
      sx = longint'(coef_cos) * px + longint'(coef_sin) * py + longint'(src_w - 1) * HALF;
      sy = -longint'(coef_sin) * px + longint'(coef_cos) * py + longint'(src_h - 1) * HALF;
      ox = round_half_away(sx);
      oy = round_half_away(sy);
      p.dest_x = x;
      p.dest_y = y;
      p.hit    = (ox >= 0) && (oy >= 0) && (ox < src_w) && (oy < src_h);
      p.src_x  = p.hit ? ox[OUT_BITS-1:0] : '0;
      p.src_y  = p.hit ? oy[OUT_BITS-1:0] : '0;
      return p;
   endfunction

   task automatic note_mismatch(string field, src_point_type want, int want_val, int got_val);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t: mismatch on %s for dest (%0d,%0d): expected %0d, got %0d",
                  $time, field, want.dest_x, want.dest_y, want_val, got_val);
      end
   endtask

   always @(posedge clock) begin
      src_point_type want;
      if (reset) begin
         coef_cos = COEF_BITS'(longint'(1) << FRAC_BITS);
         coef_sin = '0;
         center_x = '0;
         center_y = '0;
         src_w    = 1;
         src_h    = 1;
         src_point_q.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_COEF_COS:      coef_cos = csr_mon.data[COEF_BITS-1:0];
               CSR_COEF_SIN:      coef_sin = csr_mon.data[COEF_BITS-1:0];
               CSR_DEST_CENTER_X: center_x = csr_mon.data[COORD_BITS-1:0];
               CSR_DEST_CENTER_Y: center_y = csr_mon.data[COORD_BITS-1:0];
               CSR_SRC_WIDTH:     src_w    = clamp_size(csr_mon.data[SIZE_BITS-1:0]);
               CSR_SRC_HEIGHT:    src_h    = clamp_size(csr_mon.data[SIZE_BITS-1:0]);
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (src_point_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%0t: result transaction with none expected: hit %0d src (%0d,%0d)",
                           $time, rsp_mon.hit, rsp_mon.src_x, rsp_mon.src_y);
               end
            end else begin
               want = src_point_q.pop_front();
               if (rsp_mon.hit !== want.hit)
                  note_mismatch("hit", want, want.hit, rsp_mon.hit);
               if (rsp_mon.src_x !== want.src_x)
                  note_mismatch("src_x", want, want.src_x, rsp_mon.src_x);
               if (rsp_mon.src_y !== want.src_y)
                  note_mismatch("src_y", want, want.src_y, rsp_mon.src_y);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            src_point_q.push_back(map_pixel(req_mon.dest_x, req_mon.dest_y));
         end
      end
      pending_results <= src_point_q.size();
   end

endmodule

@@ tb/sv/rotozoom_inverse_map_top_tb.sv @@
// Testbench top for the rotozoom inverse mapper: clock, reset, stimulus, watchdog and verdict.
module rotozoom_inverse_map_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rim_pkg::*;

   localparam int COORD_BITS      = 12;
   localparam int SRC_MAX         = 256;
   localparam int FRAC_BITS       = 16;
   localparam int OUT_BITS        = 8;
   localparam int COEF_BITS       = FRAC_BITS + 2;
   localparam int DRAIN_CYCLES    = 10;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int STALL_LIMIT     = 2000;
   localparam int RANDOM_PHASES   = 12;
   localparam int PHASE_ITEMS     = 150;

   localparam csr_index_type CSR_SPARE = CSR_SRC_HEIGHT + csr_index_type'(1);

   typedef struct {
      logic [COEF_BITS-1:0]  coef_cos;
      logic [COEF_BITS-1:0]  coef_sin;
      logic [COORD_BITS-1:0] cx;
      logic [COORD_BITS-1:0] cy;
      logic [8:0]            w;
      logic [8:0]            h;
   } map_setup_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_results;
   int   idle_cycles = 0;
   bit   steady = 1'b0;
   bit   hold_off_req = 1'b0;

   rim_req_if #(.COORD_BITS(COORD_BITS)) req_chan();
   rim_rsp_if #(.OUT_BITS(OUT_BITS))     rsp_chan();
   rim_csr_if #(.DATA_BITS(COEF_BITS))   csr_chan();

   rotozoom_inverse_map_top #(
      .COORD_BITS(COORD_BITS),
      .SRC_MAX   (SRC_MAX),
      .FRAC_BITS (FRAC_BITS)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   rotozoom_inverse_map_checker #(
      .COORD_BITS(COORD_BITS),
      .SRC_MAX   (SRC_MAX),
      .FRAC_BITS (FRAC_BITS),
      .OUT_BITS  (OUT_BITS)
   ) map_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_mon        (csr_chan),
      .fail_count     (fail_count),
      .pending_results(pending_results)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
             (csr_chan.valid && csr_chan.ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_chan.ready <= steady || ($urandom_range(99) >= 7);
      end
   end

   function automatic map_setup_type make_setup(logic [COEF_BITS-1:0] coef_cos,
                                                 logic [COEF_BITS-1:0] coef_sin,
                                                 logic [COORD_BITS-1:0] cx,
                                                 logic [COORD_BITS-1:0] cy,
                                                 logic [8:0] w, logic [8:0] h);
      map_setup_type s;
      s.coef_cos = coef_cos;
      s.coef_sin = coef_sin;
      s.cx       = cx;
      s.cy       = cy;
      s.w        = w;
      s.h        = h;
      return s;
   endfunction

   function automatic logic [COEF_BITS-1:0] pick_coef();
      case ($urandom_range(9))
         0:       return COEF_BITS'(-65536);
         1:       return COEF_BITS'(65536);
         2:       return 18'h20000;
         3:       return 18'h1FFFF;
         4:       return '0;
         default: return COEF_BITS'($urandom_range(131072) - 65536);
      endcase
   endfunction

   function automatic logic [8:0] pick_size();
      case ($urandom_range(9))
         0:       return 9'd1;
         1:       return 9'd256;
         2:       return 9'd0;
         3:       return 9'($urandom_range(257, 511));
         default: return 9'($urandom_range(1, 256));
      endcase
   endfunction

   function automatic logic [COORD_BITS-1:0] pick_center();
      case ($urandom_range(5))
         0:       return '0;
         1:       return '1;
         default: return COORD_BITS'($urandom);
      endcase
   endfunction

   task automatic send_item(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y);
      int gap;
      if (!steady && $urandom_range(99) < 3) begin
         req_chan.valid <= 1'b0;
         gap = $urandom_range(1, 4);
         repeat (gap) @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.dest_x <= x;
      req_chan.dest_y <= y;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [COEF_BITS-1:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= data;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
   endtask

   // upper data bits above the centre and size fields are junk the block must drop
   task automatic load_setup(map_setup_type s);
      drain();
      write_reg(CSR_COEF_COS, s.coef_cos);
      write_reg(CSR_COEF_SIN, s.coef_sin);
      write_reg(CSR_DEST_CENTER_X, {6'($urandom), s.cx});
      write_reg(CSR_DEST_CENTER_Y, {6'($urandom), s.cy});
      write_reg(CSR_SRC_WIDTH, {9'($urandom), s.w});
      write_reg(CSR_SRC_HEIGHT, {9'($urandom), s.h});
      write_reg(CSR_SPARE + csr_index_type'($urandom_range(1)), COEF_BITS'($urandom));
      csr_chan.valid <= 1'b0;
   endtask

   task automatic send_random_item(map_setup_type s, int spread);
      logic [COORD_BITS-1:0] x, y;
      if ($urandom_range(99) < 75) begin
         x = s.cx + COORD_BITS'($urandom_range(2 * spread) - spread);
         y = s.cy + COORD_BITS'($urandom_range(2 * spread) - spread);
      end else begin
         x = COORD_BITS'($urandom);
         y = COORD_BITS'($urandom);
      end
      send_item(x, y);
   endtask

   initial begin
      map_setup_type s;
      int            spread;
      req_chan.valid  <= 1'b0;
      req_chan.dest_x <= '0;
      req_chan.dest_y <= '0;
      csr_chan.valid  <= 1'b0;
      csr_chan.index  <= CSR_COEF_COS;
      csr_chan.data   <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset settings: identity onto a single source pixel
      send_item(12'd0, 12'd0);
      send_item(12'd1, 12'd0);
      send_item(12'd0, 12'd1);
      send_item(12'd4095, 12'd4095);

      // unit scale, full source: rounding at both grid edges
      load_setup(make_setup(18'h10000, '0, 12'd2048, 12'd2048, 9'd256, 9'd256));
      send_item(12'd2048, 12'd2048);
      send_item(12'd1920, 12'd1920);
      send_item(12'd1921, 12'd1921);
      send_item(12'd2175, 12'd2175);
      send_item(12'd2176, 12'd2176);
      send_item(12'd0, 12'd4095);

      // negative values round half away from zero: -0.4 still hits
      load_setup(make_setup(COEF_BITS'(-26214), '0, 12'd1, 12'd1, 9'd1, 9'd1));
      send_item(12'd2, 12'd2);
      send_item(12'd0, 12'd0);
      send_item(12'd3, 12'd3);

      // coefficients at full signed range, oversized source saturates
      load_setup(make_setup(18'h1FFFF, 18'h20000, 12'd4095, 12'd4095, 9'd511, 9'd300));
      send_item(12'd4095, 12'd4095);
      send_item(12'd0, 12'd0);
      send_item(12'd4094, 12'd4095);
      send_item(12'd4095, 12'd4094);

      // zero-sized source never hits
      load_setup(make_setup(18'h10000, '0, '0, '0, 9'd0, 9'd256));
      send_item(12'd0, 12'd0);
      load_setup(make_setup(18'h10000, '0, '0, '0, 9'd256, 9'd0));
      send_item(12'd0, 12'd0);

      // quarter turn
      load_setup(make_setup('0, 18'h10000, 12'd10, 12'd10, 9'd16, 9'd16));
      send_item(12'd10, 12'd10);
      send_item(12'd17, 12'd3);
      send_item(12'd3, 12'd17);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         s = make_setup(pick_coef(), pick_coef(), pick_center(), pick_center(),
                        pick_size(), pick_size());
         load_setup(s);
         spread = ($urandom_range(3) == 0) ? 600 : int'((s.w > s.h) ? s.w : s.h) / 2 + 8;
         steady = (phase == 3);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 5 && n == 40) hold_off_req = 1'b1;
            if (phase == 7 && n == 75) drain();
            send_random_item(s, spread);
         end
         steady = 1'b0;
      end

      drain();
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
